/* rtl/core/rgb2yuv_pkg.sv */
`default_nettype none

package rgb2yuv_pkg;

  // Widths of the configuration registers and the index of each register.
  localparam int unsigned CFG_DIM_W   = 13;
  localparam int unsigned CFG_BPP_W   = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_DIM_W-1:0] RESET_IMAGE_WIDTH     = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RESET_IMAGE_HEIGHT    = 13'd480;
  localparam logic [CFG_BPP_W-1:0] RESET_BYTES_PER_PIXEL = 3'd3;

  // Byte slots of red, green and blue, and the slot of the last byte for three-byte and four-byte pixels.
  localparam logic [1:0] SLOT_RED        = 2'd0;
  localparam logic [1:0] SLOT_GREEN      = 2'd1;
  localparam logic [1:0] SLOT_BLUE       = 2'd2;
  localparam logic [1:0] SLOT_LAST_THREE = 2'd2;
  localparam logic [1:0] SLOT_LAST_FOUR  = 2'd3;

  // Depth of the pixel queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // BT.601 coefficient magnitudes; signs are applied in the arithmetic.
  localparam logic [15:0] Y_R_COEF  = 16'd66;
  localparam logic [15:0] Y_G_COEF  = 16'd129;
  localparam logic [15:0] Y_B_COEF  = 16'd25;
  localparam logic [15:0] CB_R_COEF = 16'd38;
  localparam logic [15:0] CB_G_COEF = 16'd74;
  localparam logic [15:0] CB_B_COEF = 16'd112;
  localparam logic [15:0] CR_R_COEF = 16'd112;
  localparam logic [15:0] CR_G_COEF = 16'd94;
  localparam logic [15:0] CR_B_COEF = 16'd18;
  localparam logic [15:0] ROUND_BIAS = 16'd128;
  localparam logic [7:0]  Y_OFFSET   = 8'd16;

  // One gathered pixel with its position flags.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       chroma_valid;
    logic       frame_end;
  } pixel_t;

endpackage

`default_nettype wire

/* rtl/core/rgb2yuv_queue.sv */
`default_nettype none

// Short first-in first-out queue of pixels. DEPTH must be a power of two.
module rgb2yuv_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rgb2yuv_pkg::pixel_t push_data,
  input  wire logic                pop,
  output rgb2yuv_pkg::pixel_t      pop_data,
  output logic                     full,
  output logic                     empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rgb2yuv_pkg::pixel_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // The front never pushes into a full queue, and the back never pops an empty one.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue popped while empty");

endmodule

`default_nettype wire

/* rtl/core/rgb2yuv_front.sv */
`default_nettype none

// Gathers pixel bytes, tracks the raster position and classifies each pixel.
module rgb2yuv_front #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           in_pixel_byte,
  input  wire logic                                 cfg_write,
  input  wire logic [rgb2yuv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rgb2yuv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output rgb2yuv_pkg::pixel_t                       q_data
);

  localparam int unsigned DIM_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned CMP_W =
    ((DIM_W >= rgb2yuv_pkg::CFG_DIM_W) ? DIM_W : rgb2yuv_pkg::CFG_DIM_W) + 1;

  logic [rgb2yuv_pkg::CFG_DIM_W-1:0] width_r;
  logic [rgb2yuv_pkg::CFG_DIM_W-1:0] height_r;
  logic [rgb2yuv_pkg::CFG_BPP_W-1:0] bpp_r;

  logic [1:0]       slot_r, slot_nxt;
  logic [7:0]       red_r, red_nxt;
  logic [7:0]       green_r, green_nxt;
  logic [7:0]       blue_r, blue_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic             accept;
  logic [1:0]       last_slot;
  logic             pixel_done;
  logic [CMP_W-1:0] width_clamp;
  logic [CMP_W-1:0] height_clamp;
  logic             last_col;
  logic             last_row;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rgb2yuv_pkg::RESET_IMAGE_WIDTH;
      height_r <= rgb2yuv_pkg::RESET_IMAGE_HEIGHT;
      bpp_r    <= rgb2yuv_pkg::RESET_BYTES_PER_PIXEL;
    end else if (cfg_write) begin
      case (cfg_index)
        rgb2yuv_pkg::REG_IMAGE_WIDTH: width_r <= cfg_data;
        rgb2yuv_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        rgb2yuv_pkg::REG_BYTES_PER_PIXEL: bpp_r <= cfg_data[rgb2yuv_pkg::CFG_BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    width_clamp = CMP_W'(width_r);
    if (width_clamp == '0) begin
      width_clamp = CMP_W'(1);
    end else if (width_clamp > CMP_W'(MAX_DIMENSION)) begin
      width_clamp = CMP_W'(MAX_DIMENSION);
    end
    height_clamp = CMP_W'(height_r);
    if (height_clamp == '0) begin
      height_clamp = CMP_W'(1);
    end else if (height_clamp > CMP_W'(MAX_DIMENSION)) begin
      height_clamp = CMP_W'(MAX_DIMENSION);
    end
  end

  // Counts at or past their last value end the row or frame.
  assign last_col = CMP_W'(col_r) >= (width_clamp - CMP_W'(1));
  assign last_row = CMP_W'(row_r) >= (height_clamp - CMP_W'(1));

  // Four or more bytes per pixel ends a pixel at slot three, else at slot two.
  assign last_slot  = (bpp_r >= 3'd4) ? rgb2yuv_pkg::SLOT_LAST_FOUR
                                      : rgb2yuv_pkg::SLOT_LAST_THREE;
  assign pixel_done = (slot_r >= last_slot);
  assign q_push     = accept && pixel_done;

  // The word pushed to the queue; blue comes straight from the input byte when the pixel ends at slot two.
  always_comb begin
    q_data.red          = red_r;
    q_data.green        = green_r;
    q_data.blue         = (slot_r == rgb2yuv_pkg::SLOT_BLUE) ? in_pixel_byte : blue_r;
    q_data.chroma_valid = !row_r[0] && !col_r[0];
    q_data.frame_end    = last_col && last_row;
  end

  // Byte gathering and raster position.
  always_comb begin
    slot_nxt  = slot_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept && !pixel_done) begin
      case (slot_r)
        rgb2yuv_pkg::SLOT_RED: red_nxt = in_pixel_byte;
        rgb2yuv_pkg::SLOT_GREEN: green_nxt = in_pixel_byte;
        default: blue_nxt = in_pixel_byte;
      endcase
      slot_nxt = slot_r + 2'd1;
    end else if (accept) begin
      slot_nxt = rgb2yuv_pkg::SLOT_RED;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + DIM_W'(1);
      end else begin
        col_nxt = col_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= rgb2yuv_pkg::SLOT_RED;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      slot_r  <= slot_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // The last pixel of a frame returns the position to the top-left corner.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap after frame end");

endmodule

`default_nettype wire

/* rtl/core/rgb2yuv_back.sv */
`default_nettype none

// Converts queued pixels to Y, Cb and Cr in a sum stage and an output register.
module rgb2yuv_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire rgb2yuv_pkg::pixel_t q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_luma,
  output logic [7:0]               out_chroma_blue,
  output logic [7:0]               out_chroma_red,
  output logic                     out_chroma_valid,
  output logic                     out_frame_end
);

  typedef struct packed {
    logic [15:0] y_sum;
    logic [15:0] cb_sum;
    logic [15:0] cr_sum;
    logic        chroma_valid;
    logic        frame_end;
  } sums_t;

  sums_t      sums_r, sums_nxt;
  logic       sums_valid_r;
  logic [7:0] luma_r;
  logic [7:0] cb_r;
  logic [7:0] cr_r;
  logic       cvalid_r;
  logic       fend_r;
  logic       out_valid_r;

  logic [15:0] red_w;
  logic [15:0] green_w;
  logic [15:0] blue_w;
  logic        out_adv;
  logic        sums_adv;

  // Pipeline advance: each stage moves when the stage after it frees up.
  assign out_adv  = !out_valid_r || !out_stall;
  assign sums_adv = !sums_valid_r || out_adv;
  assign q_pop    = !q_empty && sums_adv;

  assign red_w   = {8'd0, q_data.red};
  assign green_w = {8'd0, q_data.green};
  assign blue_w  = {8'd0, q_data.blue};

  // Weighted sums. Chroma sums fit 16 bits signed, so wrapping arithmetic is exact.
  always_comb begin
    sums_nxt.y_sum  = red_w * rgb2yuv_pkg::Y_R_COEF + green_w * rgb2yuv_pkg::Y_G_COEF
                    + blue_w * rgb2yuv_pkg::Y_B_COEF + rgb2yuv_pkg::ROUND_BIAS;
    sums_nxt.cb_sum = blue_w * rgb2yuv_pkg::CB_B_COEF - red_w * rgb2yuv_pkg::CB_R_COEF
                    - green_w * rgb2yuv_pkg::CB_G_COEF + rgb2yuv_pkg::ROUND_BIAS;
    sums_nxt.cr_sum = red_w * rgb2yuv_pkg::CR_R_COEF - green_w * rgb2yuv_pkg::CR_G_COEF
                    - blue_w * rgb2yuv_pkg::CR_B_COEF + rgb2yuv_pkg::ROUND_BIAS;
    sums_nxt.chroma_valid = q_data.chroma_valid;
    sums_nxt.frame_end    = q_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (sums_adv) begin
        sums_valid_r <= !q_empty;
      end
      if (out_adv) begin
        out_valid_r <= sums_valid_r;
      end
    end
  end

  // Payload registers. Floor division by 256 plus 128 flips the sign bit of the sum.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sums_r <= sums_nxt;
    end
    if (out_adv && sums_valid_r) begin
      luma_r   <= sums_r.y_sum[15:8] + rgb2yuv_pkg::Y_OFFSET;
      cb_r     <= sums_r.chroma_valid ? {~sums_r.cb_sum[15], sums_r.cb_sum[14:8]} : 8'd0;
      cr_r     <= sums_r.chroma_valid ? {~sums_r.cr_sum[15], sums_r.cr_sum[14:8]} : 8'd0;
      cvalid_r <= sums_r.chroma_valid;
      fend_r   <= sums_r.frame_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = luma_r;
  assign out_chroma_blue  = cb_r;
  assign out_chroma_red   = cr_r;
  assign out_chroma_valid = cvalid_r;
  assign out_frame_end    = fend_r;

  // A word without chroma carries zero in both chroma fields.
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !cvalid_r) |-> (cb_r == 8'd0 && cr_r == 8'd0))
    else $error("chroma fields nonzero without chroma");

endmodule

`default_nettype wire

/* rtl/core/rgb_to_yuv420_converter_unit.sv */
`default_nettype none

// Channel  Direction  Handshake            Word
// in_      input      in_valid / in_stall  in_pixel_byte, one byte of interleaved pixel data
// out_     output     out_valid/out_stall  luma, chroma_blue, chroma_red, chroma_valid, frame_end
// cfg_     input      cfg_valid/cfg_ready  cfg_index selects register, cfg_data is written
//
// One input byte is taken every cycle while in_stall is low; a pixel result follows every three or four bytes.
// After its last byte, a result passes through the queue, the sum stage and the output register.
// in_stall rises only when the two-entry pixel queue is full under output back-pressure.
// Synchronous reset sets width 640, height 480, three bytes per pixel and the raster to origin.
// cfg_ready is always high; no clearing pass follows reset.
module rgb_to_yuv420_converter_unit #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [7:0]                          in_pixel_byte,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [7:0]                               out_luma,
  output logic [7:0]                               out_chroma_blue,
  output logic [7:0]                               out_chroma_red,
  output logic                                     out_chroma_valid,
  output logic                                     out_frame_end,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  rgb2yuv_pkg::pixel_t q_wr_data;
  rgb2yuv_pkg::pixel_t q_rd_data;

  assign cfg_ready = 1'b1;

  // Front part: byte gathering, position and configuration.
  rgb2yuv_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_byte (in_pixel_byte),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  // Pixel queue between the two parts.
  rgb2yuv_queue #(
    .DEPTH(rgb2yuv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back part: color conversion and output register.
  rgb2yuv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rd_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_luma         (out_luma),
    .out_chroma_blue  (out_chroma_blue),
    .out_chroma_red   (out_chroma_red),
    .out_chroma_valid (out_chroma_valid),
    .out_frame_end    (out_frame_end)
  );

endmodule

`default_nettype wire
